FILE: hw/rtl/mexp_pkg.sv
package mexp_pkg;

    localparam int BASE_W = 63;
    localparam int EXP_IN_W = 32;
    localparam int MOD_REG_W = 31;
    localparam int RES_W = 31;
    localparam int DIV_W = 64;
    localparam int STEP_W = 6;
    localparam int UPC_W = 4;

    localparam logic [MOD_REG_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Program addresses.
    localparam logic [UPC_W-1:0] S_IDLE       = 4'd0;
    localparam logic [UPC_W-1:0] S_CHK_EXP    = 4'd1;
    localparam logic [UPC_W-1:0] S_INIT_ACC   = 4'd2;
    localparam logic [UPC_W-1:0] S_RED_BASE   = 4'd3;
    localparam logic [UPC_W-1:0] S_WAIT_BASE  = 4'd4;
    localparam logic [UPC_W-1:0] S_SET_BASE   = 4'd5;
    localparam logic [UPC_W-1:0] S_BIT        = 4'd6;
    localparam logic [UPC_W-1:0] S_MUL_ACC    = 4'd7;
    localparam logic [UPC_W-1:0] S_RED_ACC    = 4'd8;
    localparam logic [UPC_W-1:0] S_WAIT_ACC   = 4'd9;
    localparam logic [UPC_W-1:0] S_WR_ACC     = 4'd10;
    localparam logic [UPC_W-1:0] S_MUL_SQ     = 4'd11;
    localparam logic [UPC_W-1:0] S_RED_SQ     = 4'd12;
    localparam logic [UPC_W-1:0] S_WAIT_SQ    = 4'd13;
    localparam logic [UPC_W-1:0] S_WR_SQ      = 4'd14;
    localparam logic [UPC_W-1:0] S_DONE       = 4'd15;

    typedef enum logic [2:0] {
        C_NEXT,
        C_NO_IN,
        C_EXP_ZERO,
        C_MOD_LE1,
        C_RED_BUSY,
        C_BIT_CLEAR,
        C_MORE_BITS,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        logic             idle;
        logic             ld_in;
        logic             acc_init;
        logic             red_base;
        logic             red_prod;
        logic             mul_en;
        logic             mul_sq;
        logic             wr_acc;
        logic             wr_b;
        logic             shift_e;
        logic             push_out;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic exp_zero;
        logic mod_le1;
        logic red_busy;
        logic bit_clear;
        logic more_bits;
        logic out_full;
    } t_status;

    function automatic t_uword rom_word(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '0;
        w.cond = C_NEXT;
        unique case (addr)
            S_IDLE: begin
                w.idle = 1'b1;
                w.ld_in = 1'b1;
                w.cond = C_NO_IN;
                w.target = S_IDLE;
            end
            S_CHK_EXP: begin
                w.cond = C_EXP_ZERO;
                w.target = S_DONE;
            end
            S_INIT_ACC: begin
                w.acc_init = 1'b1;
                w.cond = C_MOD_LE1;
                w.target = S_DONE;
            end
            S_RED_BASE: begin
                w.red_base = 1'b1;
            end
            S_WAIT_BASE: begin
                w.cond = C_RED_BUSY;
                w.target = S_WAIT_BASE;
            end
            S_SET_BASE: begin
                w.wr_b = 1'b1;
            end
            S_BIT: begin
                w.cond = C_BIT_CLEAR;
                w.target = S_MUL_SQ;
            end
            S_MUL_ACC: begin
                w.mul_en = 1'b1;
            end
            S_RED_ACC: begin
                w.red_prod = 1'b1;
            end
            S_WAIT_ACC: begin
                w.cond = C_RED_BUSY;
                w.target = S_WAIT_ACC;
            end
            S_WR_ACC: begin
                w.wr_acc = 1'b1;
            end
            S_MUL_SQ: begin
                w.mul_en = 1'b1;
                w.mul_sq = 1'b1;
            end
            S_RED_SQ: begin
                w.red_prod = 1'b1;
            end
            S_WAIT_SQ: begin
                w.cond = C_RED_BUSY;
                w.target = S_WAIT_SQ;
            end
            S_WR_SQ: begin
                w.wr_b = 1'b1;
                w.shift_e = 1'b1;
                w.cond = C_MORE_BITS;
                w.target = S_BIT;
            end
            S_DONE: begin
                w.push_out = 1'b1;
                w.cond = C_OUT_FULL;
                w.target = S_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/mexp_seq.sv
module mexp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mexp_pkg::t_status i_status,
    output mexp_pkg::t_uword  o_ctrl
);

    logic [mexp_pkg::UPC_W-1:0] r_upc;
    logic [mexp_pkg::UPC_W-1:0] n_upc;
    mexp_pkg::t_uword           w;
    logic                       jump;

    assign w = mexp_pkg::rom_word(r_upc);
    assign o_ctrl = w;

    always_comb begin
        unique case (w.cond)
            mexp_pkg::C_NEXT:      jump = 1'b0;
            mexp_pkg::C_NO_IN:     jump = !i_status.in_valid;
            mexp_pkg::C_EXP_ZERO:  jump = i_status.exp_zero;
            mexp_pkg::C_MOD_LE1:   jump = i_status.mod_le1;
            mexp_pkg::C_RED_BUSY:  jump = i_status.red_busy;
            mexp_pkg::C_BIT_CLEAR: jump = i_status.bit_clear;
            mexp_pkg::C_MORE_BITS: jump = i_status.more_bits;
            mexp_pkg::C_OUT_FULL:  jump = i_status.out_full;
            default:               jump = 1'b0;
        endcase
        // The last step falls through to the idle step by wrapping.
        n_upc = jump ? w.target : mexp_pkg::UPC_W'(r_upc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= mexp_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

FILE: hw/rtl/mexp_reduce.sv
module mexp_reduce #(
    parameter int MOD_WIDTH = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mexp_pkg::DIV_W-1:0]   i_dividend,
    input  logic [mexp_pkg::STEP_W-1:0]  i_steps,
    input  logic [MOD_WIDTH-1:0]         i_modulus,
    output logic                         o_busy,
    output logic [MOD_WIDTH-1:0]         o_rem
);

    logic [mexp_pkg::DIV_W-1:0]  r_div;
    logic [MOD_WIDTH-1:0]        r_rem;
    logic [mexp_pkg::STEP_W-1:0] r_cnt;
    logic [MOD_WIDTH-1:0]        rem1;
    logic [MOD_WIDTH-1:0]        rem2;

    // One restoring step: the remainder stays below the modulus, so the
    // shifted value is below twice the modulus and one subtract suffices.
    function automatic logic [MOD_WIDTH-1:0] rstep(
        input logic [MOD_WIDTH-1:0] r,
        input logic                 b,
        input logic [MOD_WIDTH-1:0] m
    );
        logic [MOD_WIDTH:0] t;
        t = {r, b};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[MOD_WIDTH-1:0];
    endfunction

    assign rem1 = rstep(r_rem, r_div[mexp_pkg::DIV_W-1], i_modulus);
    assign rem2 = rstep(rem1, r_div[mexp_pkg::DIV_W-2], i_modulus);
    assign o_busy = (r_cnt != '0);
    assign o_rem = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_rem <= '0;
        end else if (o_busy) begin
            r_div <= r_div << 2;
            r_rem <= rem2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: hw/rtl/modular_exponentiation.sv
// A zero exponent goes straight to the result, and a modulus of 0 or 1 goes to it once the
// accumulator is set to zero; otherwise the base is reduced, then each exponent bit up to the
// highest set bit costs a squaring, and each set bit also a multiply into the accumulator.
// Throughput: one item at a time; the shared remainder unit, two bits per cycle, sets it.
// Reset (synchronous, active low) idles the sequencer, empties the output register and
// loads the modulus with 1000000007.
module modular_exponentiation #(
    parameter int EXP_WIDTH = 32,
    parameter int MOD_WIDTH = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mexp_pkg::MOD_REG_W-1:0] i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mexp_pkg::BASE_W-1:0]    i_base_value,
    input  logic [mexp_pkg::EXP_IN_W-1:0]  i_exponent,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mexp_pkg::RES_W-1:0]     o_power_result
);

    localparam int SCAN_BITS = (EXP_WIDTH < mexp_pkg::EXP_IN_W) ? EXP_WIDTH
                                                                : mexp_pkg::EXP_IN_W;
    localparam int PROD_W = 2 * MOD_WIDTH;
    localparam int PAD_W = mexp_pkg::DIV_W - PROD_W;

    logic [mexp_pkg::MOD_REG_W-1:0] r_modulus;
    logic [mexp_pkg::BASE_W-1:0]    r_base;
    logic [SCAN_BITS-1:0]           r_e;
    logic [MOD_WIDTH-1:0]           r_acc;
    logic [MOD_WIDTH-1:0]           r_b;
    logic [PROD_W-1:0]              r_prod;
    logic                           r_out_valid;
    logic [mexp_pkg::RES_W-1:0]     r_out;

    logic [MOD_WIDTH-1:0]           m;
    logic                           mod_le1;
    logic                           out_full;
    logic                           push;
    logic [MOD_WIDTH-1:0]           mul_a;
    logic                           red_start;
    logic [mexp_pkg::DIV_W-1:0]     red_dividend;
    logic [mexp_pkg::STEP_W-1:0]    red_steps;
    logic                           red_busy;
    logic [MOD_WIDTH-1:0]           red_rem;
    mexp_pkg::t_uword               ctrl;
    mexp_pkg::t_status              status;

    assign m = r_modulus[MOD_WIDTH-1:0];
    assign mod_le1 = ((m >> 1) == '0);
    assign out_full = r_out_valid && i_out_stall;
    assign push = ctrl.push_out && !out_full;

    assign status.in_valid  = i_in_valid;
    assign status.exp_zero  = (r_e == '0);
    assign status.mod_le1   = mod_le1;
    assign status.red_busy  = red_busy;
    assign status.bit_clear = !r_e[0];
    assign status.more_bits = ((r_e >> 1) != '0);
    assign status.out_full  = out_full;

    mexp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // Products sit at the top of the dividend so only their 2*MOD_WIDTH bits are scanned.
    assign red_start = ctrl.red_base || ctrl.red_prod;
    assign red_dividend = ctrl.red_base ? {1'b0, r_base}
                                        : ({{PAD_W{1'b0}}, r_prod} << PAD_W);
    assign red_steps = ctrl.red_base ? mexp_pkg::STEP_W'(mexp_pkg::DIV_W / 2)
                                     : mexp_pkg::STEP_W'(MOD_WIDTH);

    mexp_reduce #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_reduce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (red_start),
        .i_dividend (red_dividend),
        .i_steps    (red_steps),
        .i_modulus  (m),
        .o_busy     (red_busy),
        .o_rem      (red_rem)
    );

    assign mul_a = ctrl.mul_sq ? r_b : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::MODULUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_in) begin
            r_base <= i_base_value;
        end
        if (ctrl.ld_in) begin
            r_e <= i_exponent[SCAN_BITS-1:0];
        end else if (ctrl.shift_e) begin
            r_e <= r_e >> 1;
        end
        // A zero exponent leaves the accumulator at one, even for a modulus of one.
        if (ctrl.ld_in) begin
            r_acc <= MOD_WIDTH'(1);
        end else if (ctrl.acc_init) begin
            r_acc <= mod_le1 ? '0 : MOD_WIDTH'(1);
        end else if (ctrl.wr_acc) begin
            r_acc <= red_rem;
        end
        if (ctrl.wr_b) begin
            r_b <= red_rem;
        end
        if (ctrl.mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(r_b);
        end
        if (push) begin
            r_out <= mexp_pkg::RES_W'(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall = !ctrl.idle;
    assign o_out_valid = r_out_valid;
    assign o_power_result = r_out;

endmodule

FILE: hw/rtl/mexp_checker.sv
module mexp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [mexp_pkg::RES_W-1:0]     o_power_result
);

    // After reset the output register is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A held result beat keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_power_result))
        else $error("stalled result changed");

    // Once an item is taken, no further item is taken until it is done.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // A result never appears in the cycle right after an item was taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");

    // A new result is only produced while an item is at work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);
